/* design/i2r_pkg.sv */
// Shared constants, types and helper functions for the radix digit converter.
// Used by i2r_divider and integer_to_radix_digits_unit; depends on nothing else.
package i2r_pkg;

	localparam int VALUE_BITS = 31;
	localparam int MAX_DIGITS = 31;
	localparam int RADIX_BITS = 6;
	localparam int CHAR_BITS  = 7;

	localparam int CNT_BITS     = $clog2(MAX_DIGITS + 1);
	localparam int IDX_BITS     = $clog2(MAX_DIGITS);
	localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

	localparam int TDATA_IN_BITS  = ((VALUE_BITS + 7) / 8) * 8;
	localparam int TDATA_OUT_BITS = ((CHAR_BITS + 7) / 8) * 8;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
	localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO = CHAR_BITS'(8'h30);
	localparam logic [CHAR_BITS-1:0] CHAR_A    = CHAR_BITS'(8'h41);
	localparam logic [CHAR_BITS-1:0] CHAR_Z    = CHAR_BITS'(8'h5A);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} i2r_state_t;

	// Status of the serial divider as seen by the sequencer.
	typedef struct packed {
		logic                  done;
		logic                  nz;
		logic [VALUE_BITS-1:0] quot;
		logic [RADIX_BITS-1:0] rem;
	} div_res_t;

	// Out-of-range radix settings are clamped to the nearest legal base.
	function automatic logic [RADIX_BITS-1:0] eff_base(input logic [RADIX_BITS-1:0] r);
		logic [RADIX_BITS-1:0] b;
		if (r < RADIX_MIN) begin
			b = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			b = RADIX_MAX;
		end else begin
			b = r;
		end
		return b;
	endfunction

	function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [RADIX_BITS-1:0] d);
		logic [CHAR_BITS-1:0] c;
		if (d < RADIX_BITS'(10)) begin
			c = CHAR_ZERO + CHAR_BITS'(d);
		end else if (d < RADIX_MAX) begin
			c = CHAR_A + CHAR_BITS'(d - RADIX_BITS'(10));
		end else begin
			c = CHAR_Z;
		end
		return c;
	endfunction

endpackage

/* design/integer_to_radix_digits_unit.sv */
// Top level of the radix digit converter: input stream, digit sequencer, digit buffer
// and output stream register. Depends on i2r_pkg and i2r_divider.
//
// Converts one unsigned VALUE_BITS-bit word into its digits in base 2 to 36, sent most
// significant first as ASCII characters, with tlast on the final digit. Each digit costs
// one division in the bit-serial divider, and the readout then sends one digit per cycle
// unless m_tready holds it; the next word is taken only once the final digit has been
// loaded into the output stream register. s_tready is high only between conversions.
// The radix setting is clamped to 2 and 36 when it is sampled, as a word is accepted.
module integer_to_radix_digits_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [i2r_pkg::RADIX_BITS-1:0]     cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata: [30:0] value, upper bits zero.
	input  logic [i2r_pkg::TDATA_IN_BITS-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata: [6:0] digit_char, upper bit zero.
	output logic [i2r_pkg::TDATA_OUT_BITS-1:0] m_tdata,
	// m_tlast: last_digit.
	output logic                               m_tlast
);
	import i2r_pkg::*;

	i2r_state_t state_q, state_d;

	logic [RADIX_BITS-1:0] radix_q;
	logic [RADIX_BITS-1:0] base_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [IDX_BITS-1:0]   rd_q;
	logic                  m_tvalid_q;
	logic [CHAR_BITS-1:0]  m_char_q;
	logic                  m_last_q;
	logic [RADIX_BITS-1:0] digit_buf_q [MAX_DIGITS];

	logic                  in_acc;
	logic                  more;
	logic                  div_start;
	logic                  emit_load;
	logic [VALUE_BITS-1:0] div_dividend;
	div_res_t              res;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	// Keep dividing while the quotient is nonzero and the buffer has room.
	assign more     = res.nz && ((count_q + CNT_BITS'(1)) < CNT_BITS'(MAX_DIGITS));

	assign div_dividend = (state_q == ST_IDLE) ? s_tdata[VALUE_BITS-1:0] : res.quot;

	i2r_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.base     (base_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (res.done) begin
					if (more) begin
						div_start = 1'b1;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					emit_load = 1'b1;
					if (rd_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RADIX_RESET;
			count_q    <= '0;
			rd_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if (in_acc) begin
				count_q <= '0;
			end else if (state_q == ST_DIVIDE && res.done) begin
				count_q <= count_q + CNT_BITS'(1);
				if (!more) begin
					rd_q <= count_q[IDX_BITS-1:0];
				end
			end
			if (emit_load) begin
				rd_q       <= rd_q - IDX_BITS'(1);
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Remainders land least significant first and are read back from the top.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			base_q <= eff_base(radix_q);
		end
		if (state_q == ST_DIVIDE && res.done) begin
			digit_buf_q[count_q[IDX_BITS-1:0]] <= res.rem;
		end
		if (emit_load) begin
			m_char_q <= digit_to_char(digit_buf_q[rd_q]);
			m_last_q <= (rd_q == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_OUT_BITS - CHAR_BITS){1'b0}}, m_char_q};
	assign m_tlast  = m_last_q;

`ifndef ASSERT_OFF
	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (state_q == ST_DIVIDE))
		else $error("divider result outside the divide phase");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_DIGITS))
		else $error("digit count beyond buffer depth");
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && rd_q == '0) |=> (state_q == ST_IDLE && m_tvalid && m_tlast))
		else $error("final digit did not end the conversion");
`endif

endmodule

/* design/i2r_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle while busy.
// Depends on i2r_pkg for widths and the div_res_t status struct.
module i2r_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [i2r_pkg::VALUE_BITS-1:0] dividend,
	input  logic [i2r_pkg::RADIX_BITS-1:0] base,
	output i2r_pkg::div_res_t              res
);
	import i2r_pkg::*;

	localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(VALUE_BITS - 1);

	logic                    busy_q;
	logic                    done_q;
	logic                    nz_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [VALUE_BITS-1:0]   dvd_q;
	logic [RADIX_BITS-1:0]   rem_q;

	logic [RADIX_BITS:0]   trial;
	logic [RADIX_BITS:0]   diff;
	logic                  qbit;
	logic [RADIX_BITS-1:0] rem_next;

	// The partial remainder stays below the base, so it fits the radix width and
	// one extra bit covers the shifted-in dividend bit.
	always_comb begin
		trial    = {rem_q, dvd_q[VALUE_BITS-1]};
		diff     = trial - {1'b0, base};
		qbit     = (trial >= {1'b0, base});
		rem_next = qbit ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_BITS'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient bits shift in at the bottom as the dividend shifts out at the top.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			nz_q  <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], qbit};
			rem_q <= rem_next;
			nz_q  <= nz_q | qbit;
		end
	end

	assign res.done = done_q;
	assign res.nz   = nz_q;
	assign res.quot = dvd_q;
	assign res.rem  = rem_q;

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < base))
		else $error("partial remainder reached the base");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == CNT_LAST) |=> done_q)
		else $error("division finished without done");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for integer_to_radix_digits_unit: streams integers in, predicts
// the digit characters for the current radix and checks every output word in order.
// Depends on i2r_pkg and the design files; it needs nothing else.
module tb;

	localparam int VALUE_W    = i2r_pkg::VALUE_BITS;
	localparam int RADIX_W    = i2r_pkg::RADIX_BITS;
	localparam int DIGIT_SLOT = i2r_pkg::MAX_DIGITS;
	localparam int IDLE_LIMIT = 6000;
	localparam int HOLD_LONG  = 500;

	localparam logic [6:0] ASCII_ZERO    = 7'h30;
	localparam logic [6:0] ASCII_UPPER_A = 7'h41;
	localparam logic [6:0] ASCII_UPPER_Z = 7'h5A;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} digit_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RADIX_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [i2r_pkg::TDATA_IN_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [i2r_pkg::TDATA_OUT_BITS-1:0] m_tdata;
	logic m_tlast;

	digit_word_t expected_digits[$];
	logic [RADIX_W-1:0] radix_now = RADIX_W'(10);
	int mismatch_count = 0;
	int idle_cycles = 0;
	int hold_request = 0;
	bit calm = 1'b0;

	integer_to_radix_digits_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none at all in calm stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned clamp_base(input logic [RADIX_W-1:0] r);
		if (r < 2) begin
			return 2;
		end else if (r > 36) begin
			return 36;
		end
		return 32'(r);
	endfunction

	// Values that stress the digit count: full range, small, truncated, powers of the base and
	// one below them, and the largest value.
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [63:0] p;
		int unsigned b;
		int k;
		b = clamp_base(radix_now);
		p = 64'd1;
		case ($urandom_range(0, 4))
			0: begin
				return VALUE_W'($urandom());
			end
			1: begin
				return VALUE_W'($urandom_range(0, 40));
			end
			2: begin
				return VALUE_W'($urandom() >> $urandom_range(0, 31));
			end
			3: begin
				k = $urandom_range(1, 31);
				repeat (k) begin
					if (p * b <= 64'(VALUE_MAX)) begin
						p = p * b;
					end
				end
				return VALUE_W'(p - 64'($urandom_range(0, 1)));
			end
			default: begin
				return VALUE_MAX;
			end
		endcase
	endfunction

	task automatic predict_digits(input logic [VALUE_W-1:0] v);
		logic [RADIX_W-1:0] rems [DIGIT_SLOT];
		int unsigned b;
		int n;
		logic [VALUE_W-1:0] q;
		digit_word_t w;
		b = clamp_base(radix_now);
		q = v;
		n = 0;
		do begin
			rems[n] = RADIX_W'(q % b);
			n++;
			q = VALUE_W'(q / b);
		end while (q != 0 && n < DIGIT_SLOT);
		for (int k = n - 1; k >= 0; k--) begin
			if (rems[k] < 10) begin
				w.ch = ASCII_ZERO + 7'(rems[k]);
			end else if (rems[k] < 36) begin
				w.ch = ASCII_UPPER_A + 7'(rems[k] - 10);
			end else begin
				w.ch = ASCII_UPPER_Z;
			end
			w.last = (k == 0);
			expected_digits = {expected_digits, w};
		end
	endtask

	// Leaves tvalid high after the accepting edge so that a following word can go out
	// back to back; tvalid is lowered for any gap before a word and by drain_digits.
	task automatic send_value(input logic [VALUE_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(i2r_pkg::TDATA_IN_BITS - VALUE_W){1'b0}}, v};
		do begin
			@(posedge clk);
		end while (!s_tready);
		predict_digits(v);
	endtask

	task automatic drain_digits();
		s_tvalid <= 1'b0;
		while (expected_digits.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		drain_digits();
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_now = r;
	endtask

	task automatic test_reset_radix();
		send_value('0);
		send_value(VALUE_W'(1));
		send_value(VALUE_W'(9));
		send_value(VALUE_W'(10));
		send_value(VALUE_W'(1000000000));
		send_value(VALUE_MAX);
	endtask

	// Base limits, clamping of out-of-range settings and alternating bit patterns.
	task automatic test_radix_extremes();
		set_radix(RADIX_W'(2));
		send_value('0);
		send_value(VALUE_MAX);
		send_value(VALUE_W'(32'h4000_0000));
		set_radix(RADIX_W'(36));
		send_value(VALUE_W'(35));
		send_value(VALUE_W'(36));
		send_value(VALUE_MAX);
		set_radix(RADIX_W'(16));
		send_value(VALUE_W'(32'h5555_5555));
		send_value(VALUE_W'(32'h2AAA_AAAA));
		set_radix(RADIX_W'(0));
		send_value(VALUE_W'(5));
		set_radix(RADIX_W'(1));
		send_value(VALUE_W'(6));
		set_radix(RADIX_W'(37));
		send_value(VALUE_W'(35));
		set_radix(RADIX_W'(63));
		send_value(VALUE_MAX);
		send_value('0);
	endtask

	task automatic test_random_values();
		for (int phase = 0; phase < 8; phase++) begin
			calm = (phase % 3 == 1);
			case ($urandom_range(0, 5))
				0: set_radix(RADIX_W'(2));
				1: set_radix(RADIX_W'(36));
				default: set_radix(RADIX_W'($urandom_range(0, 63)));
			endcase
			repeat (10) send_value(pick_value());
		end
		calm = 1'b0;
	endtask

	// The receiver stops for a long stretch while words keep coming with no gaps.
	task automatic test_output_stall();
		set_radix(RADIX_W'(10));
		calm = 1'b1;
		hold_request = HOLD_LONG;
		repeat (8) send_value(pick_value());
		calm = 1'b0;
		drain_digits();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radix();
		test_radix_extremes();
		test_random_values();
		test_output_stall();
		drain_digits();
		repeat (40) @(posedge clk);
		if (expected_digits.size() != 0) begin
			mismatch_count += expected_digits.size();
			$display("%0d expected digit words never arrived", expected_digits.size());
		end
		if (mismatch_count == 0) begin
			$display("[integer_to_radix_digits_unit] OK");
		end else begin
			$display("[integer_to_radix_digits_unit] ERROR");
		end
		$finish;
	end

	// Receiver: random stalls, plus one long hold when a test asks for it.
	initial begin : digit_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_digits
		digit_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_digits.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected digit word: char %h last %b", m_tdata, m_tlast);
				end
			end else begin
				want = expected_digits.pop_front();
				if (m_tdata !== {1'b0, want.ch}) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("digit char mismatch: expected %h actual %h", want.ch, m_tdata);
					end
				end
				if (m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("last flag mismatch: expected %b actual %b", want.last, m_tlast);
					end
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which neither stream nor the register moves.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[integer_to_radix_digits_unit] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
